[design/pfb_pkg.sv]
package pfb_pkg;

   // Storage size and fixed field widths
   localparam int unsigned BUFFER_BYTES_DEFAULT = 1024;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned OFFSET_W = 10;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned BANKS = 8;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 11'd1024;

   // Operation codes; code 7 is unused and answers with an error
   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_TAKE   = 3'd1,
      MODE_GET    = 3'd2,
      MODE_SET    = 3'd3,
      MODE_SKIP   = 3'd4,
      MODE_TO_END = 3'd5,
      MODE_RESET  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ACCESS,
      ST_REPLY
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic [1:0]          access_width;
      logic                big_endian;
      logic [OFFSET_W-1:0] field_offset;
      logic [COUNT_W-1:0]  skip_length;
      logic [VALUE_W-1:0]  write_value;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               status;
      logic [COUNT_W-1:0] fill_level;
      logic [COUNT_W-1:0] cursor_position;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_op;
      logic check;
      logic access;
      logic reply;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

[design/pfb_channels.sv]
interface pfb_req_if;
   logic                     valid;
   logic                     ready;
   pfb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pfb_rsp_if;
   logic                     valid;
   logic                     ready;
   pfb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pfb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pfb_pkg::COUNT_W-1:0]     capacity_bytes;

   modport source (output valid, output capacity_bytes, input ready);
   modport sink (input valid, input capacity_bytes, output ready);
endinterface

[design/pfb_ctrl.sv]
module pfb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pfb_pkg::stat_type  stat,
   output pfb_pkg::cmd_type   cmd
);

   pfb_pkg::ctrl_state_type state_ff;
   pfb_pkg::ctrl_state_type state_in;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance one step per cycle; wait for the result register to free up
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pfb_pkg::ST_IDLE: begin
            // refuse transactions while reset is held so none is dropped
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_op = 1'b1;
               state_in    = pfb_pkg::ST_CHECK;
            end
         end
         pfb_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = pfb_pkg::ST_ACCESS;
         end
         pfb_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = pfb_pkg::ST_REPLY;
         end
         pfb_pkg::ST_REPLY: begin
            if (stat.out_free) begin
               cmd.reply = 1'b1;
               state_in  = pfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfb_pkg::ST_IDLE;
         end
      endcase
   end

   a_check_then_access: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfb_pkg::ST_CHECK |=> state_ff == pfb_pkg::ST_ACCESS)
      else $error("bound check not followed by bank access");

   a_access_then_reply: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfb_pkg::ST_ACCESS |=> state_ff == pfb_pkg::ST_REPLY)
      else $error("bank access not followed by reply");

   a_accept_starts_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == pfb_pkg::ST_CHECK)
      else $error("accepted transaction did not start a bound check");

endmodule

[design/pfb_datapath.sv]
module pfb_datapath #(
   parameter int unsigned BUFFER_BYTES = pfb_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pfb_pkg::cmd_type             cmd,
   output pfb_pkg::stat_type            stat,
   input  pfb_pkg::req_payload_type     req_payload,
   input  logic                         csr_write,
   input  logic [pfb_pkg::COUNT_W-1:0]  csr_capacity,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pfb_pkg::rsp_payload_type     rsp_payload
);

   localparam int unsigned ROWS  = (BUFFER_BYTES + pfb_pkg::BANKS - 1) / pfb_pkg::BANKS;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Captured operation
   logic [2:0]                   mode_ff;
   logic [1:0]                   width_ff;
   logic                         rev_ff;
   logic [pfb_pkg::OFFSET_W-1:0] offset_ff;
   logic [pfb_pkg::COUNT_W-1:0]  skip_ff;
   logic [pfb_pkg::VALUE_W-1:0]  wval_ff;

   // Buffer counters and capacity register
   logic [pfb_pkg::COUNT_W-1:0]  capacity_ff;
   logic [pfb_pkg::COUNT_W-1:0]  fill_ff;
   logic [pfb_pkg::COUNT_W-1:0]  cursor_ff;

   // Bound check results
   logic                         err_ff,  err_in;
   logic                         wr_ok_ff, wr_ok_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic [11:0]                  addr_ff, addr_in;
   logic [pfb_pkg::COUNT_W-1:0]  fill_next_ff, fill_next_in;
   logic [pfb_pkg::COUNT_W-1:0]  cursor_next_ff, cursor_next_in;

   // Bank read data and result register
   logic [7:0]                   rd_q_ff [pfb_pkg::BANKS];
   logic                         rsp_valid_ff;
   pfb_pkg::rsp_payload_type     rsp_payload_ff;

   logic [3:0]                   size;
   logic [2:0]                   size_m1;
   logic [11:0]                  bound;
   logic [11:0]                  sum_fill_size;
   logic [11:0]                  sum_cur_size;
   logic [11:0]                  sum_cur_off;
   logic [11:0]                  sum_cur_off_size;
   logic [11:0]                  sum_cur_skip;
   logic [pfb_pkg::VALUE_W-1:0]  field_value;

   assign size    = 4'b0001 << width_ff;
   assign size_m1 = 3'(size - 4'd1);

   // Capture the operation on acceptance
   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         mode_ff   <= req_payload.mode;
         width_ff  <= req_payload.access_width;
         rev_ff    <= req_payload.big_endian;
         offset_ff <= req_payload.field_offset;
         skip_ff   <= req_payload.skip_length;
         wval_ff   <= req_payload.write_value;
      end
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= pfb_pkg::CAPACITY_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_capacity;
      end
   end

   // Bound in use is the smaller of capacity and storage size
   always_comb begin
      if (32'(capacity_ff) < BUFFER_BYTES) begin
         bound = {1'b0, capacity_ff};
      end else begin
         bound = 12'(BUFFER_BYTES);
      end
   end

   assign sum_fill_size    = {1'b0, fill_ff} + {8'b0, size};
   assign sum_cur_size     = {1'b0, cursor_ff} + {8'b0, size};
   assign sum_cur_off      = {1'b0, cursor_ff} + {2'b0, offset_ff};
   assign sum_cur_off_size = sum_cur_off + {8'b0, size};
   assign sum_cur_skip     = {1'b0, cursor_ff} + {1'b0, skip_ff};

   // Check bounds, pick the byte address and the next counters
   always_comb begin
      err_in         = 1'b0;
      wr_ok_in       = 1'b0;
      rd_ok_in       = 1'b0;
      addr_in        = '0;
      fill_next_in   = fill_ff;
      cursor_next_in = cursor_ff;
      unique case (mode_ff)
         pfb_pkg::MODE_APPEND: begin
            if (sum_fill_size > bound) begin
               err_in = 1'b1;
            end else begin
               wr_ok_in     = 1'b1;
               addr_in      = {1'b0, fill_ff};
               fill_next_in = sum_fill_size[pfb_pkg::COUNT_W-1:0];
            end
         end
         pfb_pkg::MODE_TAKE: begin
            if (sum_cur_size > {1'b0, fill_ff}) begin
               err_in = 1'b1;
            end else begin
               rd_ok_in       = 1'b1;
               addr_in        = {1'b0, cursor_ff};
               cursor_next_in = sum_cur_size[pfb_pkg::COUNT_W-1:0];
            end
         end
         pfb_pkg::MODE_GET: begin
            if (sum_cur_off_size > {1'b0, fill_ff}) begin
               err_in = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
               addr_in  = sum_cur_off;
            end
         end
         pfb_pkg::MODE_SET: begin
            if (sum_cur_off_size > {1'b0, fill_ff}) begin
               err_in = 1'b1;
            end else begin
               wr_ok_in = 1'b1;
               addr_in  = sum_cur_off;
            end
         end
         pfb_pkg::MODE_SKIP: begin
            if (sum_cur_skip > {1'b0, fill_ff}) begin
               err_in = 1'b1;
            end else begin
               cursor_next_in = sum_cur_skip[pfb_pkg::COUNT_W-1:0];
            end
         end
         pfb_pkg::MODE_TO_END: begin
            cursor_next_in = fill_ff;
         end
         pfb_pkg::MODE_RESET: begin
            fill_next_in   = '0;
            cursor_next_in = '0;
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         err_ff         <= err_in;
         wr_ok_ff       <= wr_ok_in;
         rd_ok_ff       <= rd_ok_in;
         addr_ff        <= addr_in;
         fill_next_ff   <= fill_next_in;
         cursor_next_ff <= cursor_next_in;
      end
   end

   // Commit counters during the bank access
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         cursor_ff <= '0;
      end else if (cmd.access) begin
         fill_ff   <= fill_next_ff;
         cursor_ff <= cursor_next_ff;
      end
   end

   // Eight byte-wide banks; byte address a lives in bank a[2:0], row a/8
   for (genvar b = 0; b < pfb_pkg::BANKS; b++) begin : g_bank
      logic [7:0]       mem [ROWS];
      logic [2:0]       lane;
      logic [2:0]       pos;
      logic [9:0]       row_full;
      logic [ROW_W-1:0] row;
      logic             lane_used;
      logic [7:0]       wr_byte;

      assign lane      = 3'(b) - addr_ff[2:0];
      assign row_full  = {1'b0, addr_ff[11:3]} + {9'b0, (3'(b) < addr_ff[2:0])};
      assign row       = (32'(row_full) >= ROWS) ? '0 : ROW_W'(row_full);
      assign lane_used = {1'b0, lane} < size;
      assign pos       = rev_ff ? (size_m1 - lane) : lane;
      assign wr_byte   = wval_ff[{pos, 3'b000} +: 8];

      always_ff @(posedge clock) begin
         if (cmd.access && wr_ok_ff && lane_used) begin
            mem[row] <= wr_byte;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.access) begin
            rd_q_ff[b] <= mem[row];
         end
      end
   end

   // Gather the field bytes back into value order
   always_comb begin
      logic [2:0] idx;
      logic [2:0] bank;
      field_value = '0;
      for (int p = 0; p < pfb_pkg::BANKS; p++) begin
         idx  = rev_ff ? (size_m1 - 3'(p)) : 3'(p);
         bank = addr_ff[2:0] + idx;
         if (4'(p) < size) begin
            field_value[8*p +: 8] = rd_q_ff[bank];
         end
      end
   end

   // Result register parts the sink from the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_payload_ff.read_value      <= rd_ok_ff ? field_value : '0;
         rsp_payload_ff.status          <= err_ff;
         rsp_payload_ff.fill_level      <= fill_ff;
         rsp_payload_ff.cursor_position <= cursor_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_payload_ff;

   a_cursor_within_fill: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= fill_ff)
      else $error("read cursor passed the fill count");

   a_fill_within_store: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= BUFFER_BYTES)
      else $error("fill count passed the storage size");

   a_reply_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still waiting");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.status |-> rsp_payload_ff.read_value == '0)
      else $error("failed transaction returned a non-zero value");

endmodule

[design/packet_field_buffer.sv]
// Byte buffer with a fill count and a read cursor. Each request carries one
// operation: append a 1, 2, 4 or 8 byte field, take a field at the cursor,
// get or set a field at cursor plus offset, skip bytes, move the cursor to
// the end, or clear both counters. Fields are little-endian, or byte-reversed
// when big_endian is set. An access past its bound changes nothing, reads 0
// and returns status 1. Every request gives exactly one response. A request
// passes through capture, bound check, one access to the eight byte-wide
// storage banks (registered read), then result assembly into the response
// register; a new request is taken only once the last one has reached the
// response register. The response register lets the next request in while
// a response still waits. capacity_bytes is written on the csr channel,
// which is ready whenever reset is low, and should only change while idle.
module packet_field_buffer #(
   parameter int unsigned BUFFER_BYTES = pfb_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   pfb_req_if.sink      req_if,
   pfb_rsp_if.source    rsp_if,
   pfb_csr_if.sink      csr_if
);

   pfb_pkg::cmd_type  cmd;
   pfb_pkg::stat_type stat;

   // Take configuration writes whenever out of reset
   assign csr_if.ready = !reset;

   pfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfb_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_payload  (req_if.payload),
      .csr_write    (csr_if.valid),
      .csr_capacity (csr_if.capacity_bytes),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_payload  (rsp_if.payload)
   );

endmodule

[tb/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfb_pkg::*;

   localparam int unsigned STORE_BYTES   = BUFFER_BYTES_DEFAULT;
   localparam logic [2:0]  MODE_UNUSED   = 3'd7;
   localparam int unsigned SEGMENTS      = 6;
   localparam int unsigned SEGMENT_ITEMS = 215;
   localparam int unsigned EPISODE_ITEMS = 30;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 250000;

   // Shadow of the buffer: predicts one response per request transaction
   class field_buffer_mirror;
      logic [7:0]      bytes_held [STORE_BYTES];
      int unsigned     fill;
      int unsigned     cursor;
      int unsigned     capacity;
      rsp_payload_type awaited[$];
      int unsigned     failures;

      function new();
         fill = 0;
         cursor = 0;
         capacity = CAPACITY_RESET;
         failures = 0;
      endfunction

      function int unsigned bound();
         return (capacity < STORE_BYTES) ? capacity : STORE_BYTES;
      endfunction

      function logic [63:0] read_field(int unsigned at, int unsigned size, logic flip);
         logic [63:0] v;
         int unsigned pos;
         v = '0;
         for (int unsigned i = 0; i < size; i++) begin
            pos = flip ? (size - 1 - i) : i;
            v[8*pos +: 8] = bytes_held[at + i];
         end
         return v;
      endfunction

      function void write_field(int unsigned at, int unsigned size, logic flip,
                                logic [63:0] v);
         int unsigned pos;
         for (int unsigned i = 0; i < size; i++) begin
            pos = flip ? (size - 1 - i) : i;
            bytes_held[at + i] = v[8*pos +: 8];
         end
      endfunction

      // Apply an accepted request and queue the response it must produce
      function void log_request(req_payload_type r);
         rsp_payload_type e;
         int unsigned size;
         int unsigned spot;
         e = '0;
         size = 1 << r.access_width;
         spot = cursor + r.field_offset;
         case (r.mode)
            MODE_APPEND: begin
               if (fill + size > bound()) begin
                  e.status = 1'b1;
               end else begin
                  write_field(fill, size, r.big_endian, r.write_value);
                  fill += size;
               end
            end
            MODE_TAKE: begin
               if (cursor + size > fill) begin
                  e.status = 1'b1;
               end else begin
                  e.read_value = read_field(cursor, size, r.big_endian);
                  cursor += size;
               end
            end
            MODE_GET: begin
               if (spot + size > fill) e.status = 1'b1;
               else e.read_value = read_field(spot, size, r.big_endian);
            end
            MODE_SET: begin
               if (spot + size > fill) e.status = 1'b1;
               else write_field(spot, size, r.big_endian, r.write_value);
            end
            MODE_SKIP: begin
               if (cursor + r.skip_length > fill) e.status = 1'b1;
               else cursor += r.skip_length;
            end
            MODE_TO_END: begin
               cursor = fill;
            end
            MODE_RESET: begin
               fill = 0;
               cursor = 0;
            end
            default: begin
               e.status = 1'b1;
            end
         endcase
         e.fill_level = COUNT_W'(fill);
         e.cursor_position = COUNT_W'(cursor);
         awaited.push_back(e);
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         failures++;
         $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      endfunction

      // Compare a response transaction with the oldest prediction
      function void match_response(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected response: expected none, actual %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         if (got.read_value !== want.read_value)
            flag("read_value", want.read_value, got.read_value);
         if (got.status !== want.status)
            flag("status", want.status, got.status);
         if (got.fill_level !== want.fill_level)
            flag("fill_level", want.fill_level, got.fill_level);
         if (got.cursor_position !== want.cursor_position)
            flag("cursor_position", want.cursor_position, got.cursor_position);
      endfunction
   endclass

   logic clock;
   logic reset;

   pfb_req_if req_bus ();
   pfb_rsp_if rsp_bus ();
   pfb_csr_if csr_bus ();

   packet_field_buffer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   field_buffer_mirror mirror = new();

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_asked;
   int unsigned episode_left;
   bit          filling;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up on a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packet_field_buffer regression: fail");
      $finish;
   end

   // Drive response ready; a requested hold-off stalls it for a long stretch
   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check every accepted response transaction
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            mirror.match_response(rsp_bus.payload);
      end
   end

   function automatic req_payload_type make_request(logic [2:0] mode, logic [1:0] aw,
                                                    logic be, int unsigned off,
                                                    int unsigned skip, logic [63:0] val);
      req_payload_type r;
      r.mode = mode;
      r.access_width = aw;
      r.big_endian = be;
      r.field_offset = OFFSET_W'(off);
      r.skip_length = COUNT_W'(skip);
      r.write_value = val;
      return r;
   endfunction

   // Random request shaped by the shadow state: fill episodes append until
   // near the bound, read episodes mostly land inside the stored bytes
   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned size;
      int unsigned room;
      int unsigned pick;
      if (episode_left == 0) begin
         episode_left = EPISODE_ITEMS;
         filling = (mirror.fill + 8 <= mirror.bound()) && ($urandom_range(0, 9) != 0);
      end
      episode_left--;
      r.access_width = ($urandom_range(0, 99) < 60) ? 2'd3 : 2'($urandom_range(0, 3));
      r.big_endian = 1'($urandom_range(0, 1));
      r.write_value = {$urandom, $urandom};
      size = 1 << r.access_width;
      room = mirror.fill - mirror.cursor;
      if (room >= size && $urandom_range(0, 4) != 0)
         r.field_offset = OFFSET_W'($urandom_range(0, room - size));
      else
         r.field_offset = OFFSET_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 4) != 0)
         r.skip_length = COUNT_W'($urandom_range(0, room));
      else if ($urandom_range(0, 1) != 0)
         r.skip_length = COUNT_W'(1024);
      else
         r.skip_length = COUNT_W'($urandom_range(0, 1024));
      pick = $urandom_range(0, 99);
      if (filling) begin
         if (pick < 85)      r.mode = MODE_APPEND;
         else if (pick < 90) r.mode = MODE_TAKE;
         else if (pick < 94) r.mode = MODE_GET;
         else if (pick < 97) r.mode = MODE_SET;
         else if (pick < 99) r.mode = MODE_SKIP;
         else                r.mode = MODE_UNUSED;
      end else begin
         if (pick < 12)      r.mode = MODE_APPEND;
         else if (pick < 40) r.mode = MODE_TAKE;
         else if (pick < 63) r.mode = MODE_GET;
         else if (pick < 82) r.mode = MODE_SET;
         else if (pick < 91) r.mode = MODE_SKIP;
         else if (pick < 95) r.mode = MODE_TO_END;
         else if (pick < 96) r.mode = MODE_RESET;
         else if (pick < 98) r.mode = MODE_UNUSED;
         else                r.mode = MODE_TAKE;
      end
      return r;
   endfunction

   // Offer one request transaction, idling at random first
   task automatic offer(input req_payload_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mirror.log_request(item);
   endtask

   // Drop valid and wait until every response is back and the block is idle
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.capacity_bytes <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      mirror.capacity = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned phase);
      case (phase)
         0: begin
            send_idle_pct = 23;
            recv_idle_pct = 49;
         end
         1: begin
            send_idle_pct = 49;
            recv_idle_pct = 23;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   initial begin
      logic [COUNT_W-1:0] cap;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity_bytes = CAPACITY_RESET;
      hold_asked = 0;
      episode_left = 0;
      filling = 1'b1;
      set_idling(0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_capacity(11'd1024);

      // Directed: empty buffer, every width and byte order, bound edges
      offer(make_request(MODE_TAKE, 2'd3, 1'b0, 0, 0, '0));
      offer(make_request(MODE_SKIP, 2'd0, 1'b0, 0, 0, '0));
      offer(make_request(MODE_SKIP, 2'd0, 1'b0, 0, 1024, '0));
      offer(make_request(MODE_GET, 2'd0, 1'b0, 0, 0, '0));
      offer(make_request(MODE_APPEND, 2'd0, 1'b0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_request(MODE_APPEND, 2'd1, 1'b1, 0, 0, 64'h0000_0000_0000_A55A));
      offer(make_request(MODE_APPEND, 2'd2, 1'b0, 0, 0, 64'h1234_5678_DEAD_BEEF));
      offer(make_request(MODE_APPEND, 2'd3, 1'b1, 0, 0, 64'h0123_4567_89AB_CDEF));
      offer(make_request(MODE_APPEND, 2'd3, 1'b0, 0, 0, 64'h8000_0000_0000_0001));
      offer(make_request(MODE_GET, 2'd3, 1'b1, 0, 0, '0));
      offer(make_request(MODE_GET, 2'd3, 1'b0, 15, 0, '0));
      offer(make_request(MODE_GET, 2'd3, 1'b0, 16, 0, '0));
      offer(make_request(MODE_GET, 2'd0, 1'b1, 1023, 2047, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_request(MODE_SET, 2'd2, 1'b1, 3, 0, 64'hCAFE_F00D_1357_9BDF));
      offer(make_request(MODE_TAKE, 2'd0, 1'b0, 0, 0, '0));
      offer(make_request(MODE_TAKE, 2'd1, 1'b1, 0, 0, '0));
      offer(make_request(MODE_SKIP, 2'd0, 1'b0, 0, 4, '0));
      offer(make_request(MODE_GET, 2'd3, 1'b1, 0, 0, '0));
      offer(make_request(MODE_TAKE, 2'd3, 1'b0, 0, 0, '0));
      offer(make_request(MODE_TAKE, 2'd3, 1'b1, 0, 0, '0));
      offer(make_request(MODE_TAKE, 2'd0, 1'b0, 0, 0, '0));
      offer(make_request(MODE_SET, 2'd0, 1'b0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_request(MODE_UNUSED, 2'd3, 1'b1, 1023, 1024, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_request(MODE_TO_END, 2'd0, 1'b0, 0, 0, '0));
      offer(make_request(MODE_RESET, 2'd0, 1'b0, 0, 0, '0));

      // Random segments; each writes a capacity and picks an idling pattern, shared by pairs of segments
      for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         case (seg)
            0: cap = 11'd1024;
            1: cap = COUNT_W'($urandom_range(1, 300));
            2: cap = 11'd0;
            3: cap = 11'd8;
            4: cap = 11'd1024;
            default: cap = COUNT_W'($urandom_range(300, 1023));
         endcase
         write_capacity(cap);
         set_idling(seg / 2);
         // stall the response side long enough to back up the request side
         if (seg == 1) hold_asked++;
         for (int unsigned n = 0; n < SEGMENT_ITEMS; n++) offer(random_request());
      end

      settle();
      if (mirror.failures == 0)
         $display("packet_field_buffer regression: pass");
      else
         $display("packet_field_buffer regression: fail");
      $finish;
   end

endmodule
